// ===== hw/rtl/mxh_pkg.sv =====
// Shared types and constants for the multiply/xorshift hash block.
`default_nettype none

package mxh_pkg;

  // Hash constants
  localparam logic [63:0] START_XOR = 64'h6A09E667F3BCC908;
  localparam logic [63:0] WORD_MUL  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] FINAL_MUL = 64'hBF58476D1CE4E5B9;
  localparam int unsigned WORD_SHIFT  = 29;
  localparam int unsigned FINAL_SHIFT = 31;
  localparam int unsigned WORD_BYTES  = 8;

  // Partial-product select for the shared 32x32 multiplier
  localparam logic [1:0] MUL_LL = 2'd0;  // a_lo * b_lo, full 64-bit product
  localparam logic [1:0] MUL_LH = 2'd1;  // a_lo * b_hi, low half into upper word
  localparam logic [1:0] MUL_HL = 2'd2;  // a_hi * b_lo, low half into upper word

  // Controller -> datapath commands
  typedef struct packed {
    logic       capture;    // item accepted: register word, count, flags
    logic       init;       // first item of a message: load start value
    logic       load_word;  // operand <= mix ^ word, add count to total
    logic       load_fin;   // operand <= mix ^ total
    logic       mul_en;     // one multiplier step
    logic [1:0] mul_sel;    // which partial product
    logic       fin_sel;    // final constant and shift
    logic       mix_write;  // mix value <= mixed product
    logic       out_load;   // hash register <= mixed product
  } mxh_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic count_zero;
    logic last;
  } mxh_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mxh_ctrl.sv =====
// Sequencer for the hash block: handshakes, message state and multiply steps.
`default_nettype none

module mxh_ctrl
  import mxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mxh_status_t status,
  output mxh_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LOAD     = 3'd1;
  localparam logic [2:0] ST_FIN_LOAD = 3'd2;
  localparam logic [2:0] ST_MUL0     = 3'd3;
  localparam logic [2:0] ST_MUL1     = 3'd4;
  localparam logic [2:0] ST_MUL2     = 3'd5;
  localparam logic [2:0] ST_MIX      = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       in_message;
  logic       in_message_next;
  logic       fin;
  logic       fin_next;
  logic       out_valid_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next      = state;
    in_message_next = in_message;
    fin_next        = fin;
    cmd             = '0;
    cmd.fin_sel     = fin;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture     = 1'b1;
          cmd.init        = !in_message;
          in_message_next = 1'b1;
          state_next      = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!status.count_zero) begin
          cmd.load_word = 1'b1;
          state_next    = ST_MUL0;
        end else if (status.last) begin
          state_next = ST_FIN_LOAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FIN_LOAD: begin
        cmd.load_fin = 1'b1;
        fin_next     = 1'b1;
        state_next   = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LL;
        state_next  = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LH;
        state_next  = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_HL;
        state_next  = ST_MIX;
      end
      ST_MIX: begin
        if (fin) begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            cmd.out_load    = 1'b1;
            in_message_next = 1'b0;
            fin_next        = 1'b0;
            state_next      = ST_IDLE;
          end
        end else begin
          cmd.mix_write = 1'b1;
          state_next    = status.last ? ST_FIN_LOAD : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_message <= 1'b0;
      fin        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      in_message <= in_message_next;
      fin        <= fin_next;
      out_valid  <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mxh_dp.sv =====
// Datapath for the hash block: input registers, running state, shared multiplier.
`default_nettype none

module mxh_dp
  import mxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [63:0] cfg_data,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  input  logic        continue_from_last,
  input  mxh_cmd_t    cmd,
  output mxh_status_t status,
  output logic [63:0] hash
);

  logic [63:0] start_hash;
  logic [63:0] previous_result;
  logic [63:0] mix_value;
  logic [63:0] byte_total;
  logic [63:0] word_q;
  logic [3:0]  count_q;
  logic        last_q;
  logic [63:0] op_a;
  logic [63:0] acc;
  logic [63:0] hash_q;

  logic [3:0]  count_sat;
  logic [63:0] word_masked;
  logic [63:0] mul_b;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;
  logic [63:0] mix_out;

  // Saturate the count and zero the bytes above it
  assign count_sat = (byte_count > 4'(WORD_BYTES)) ? 4'(WORD_BYTES) : byte_count;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word_masked[8*i +: 8] = (4'(i) < count_sat) ? data_word[8*i +: 8] : 8'h00;
    end
  end

  // Shared 32x32 multiplier; low 64 bits of a 64x64 product over three steps
  assign mul_b = cmd.fin_sel ? FINAL_MUL : WORD_MUL;
  assign mul_x = (cmd.mul_sel == MUL_HL) ? op_a[63:32] : op_a[31:0];
  assign mul_y = (cmd.mul_sel == MUL_LH) ? mul_b[63:32] : mul_b[31:0];
  assign prod  = 64'(mul_x) * 64'(mul_y);

  // Xorshift on the finished product
  assign mix_out = cmd.fin_sel ? (acc ^ (acc >> FINAL_SHIFT))
                               : (acc ^ (acc >> WORD_SHIFT));

  // Configuration and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_hash      <= '0;
      previous_result <= '0;
    end else begin
      if (cfg_valid) begin
        start_hash <= cfg_data;
      end
      if (cmd.out_load) begin
        previous_result <= mix_out;
      end
    end
  end

  // Running mix value and byte total
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_value  <= '0;
      byte_total <= '0;
    end else begin
      if (cmd.init) begin
        mix_value  <= (continue_from_last ? previous_result : start_hash) ^ START_XOR;
        byte_total <= '0;
      end else if (cmd.mix_write) begin
        mix_value <= mix_out;
      end else if (cmd.load_word) begin
        byte_total <= byte_total + 64'(count_q);
      end
    end
  end

  // Input item, operand, accumulator and output registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      word_q  <= word_masked;
      count_q <= count_sat;
      last_q  <= last_word;
    end
    if (cmd.load_word) begin
      op_a <= mix_value ^ word_q;
    end else if (cmd.load_fin) begin
      op_a <= mix_value ^ byte_total;
    end
    if (cmd.mul_en) begin
      if (cmd.mul_sel == MUL_LL) begin
        acc <= prod;
      end else begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
    end
    if (cmd.out_load) begin
      hash_q <= mix_out;
    end
  end

  assign status.count_zero = (count_q == 4'd0);
  assign status.last       = last_q;
  assign hash              = hash_q;

endmodule

`default_nettype wire

// ===== hw/rtl/multiply_xorshift_hash64.sv =====
// A word with bytes goes through accept, operand load, three steps of the shared
// 32x32 multiplier and the xorshift before the next ready; a zero-count word
// skips the load and multiply. A last word adds the length fold and final multiply,
// then the hash sits in the output register. One item at a time; input is taken
// while a finished hash waits. Synchronous active-high reset clears start_hash,
// the previous result and the sequencer; no clearing pass.
`default_nettype none

module multiply_xorshift_hash64
  import mxh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last_word,
  input  logic        continue_from_last,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash
);

  mxh_cmd_t    cmd;
  mxh_status_t status;

  assign cfg_ready = 1'b1;

  mxh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mxh_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .data_word          (data_word),
    .byte_count         (byte_count),
    .last_word          (last_word),
    .continue_from_last (continue_from_last),
    .cmd                (cmd),
    .status             (status),
    .hash               (hash)
  );

`ifndef NO_ASSERTIONS
  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // a zero-count word that is not last frees the input right after the load state
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (byte_count == 4'd0) && !last_word) |=> ##1 in_ready)
    else $error("zero-count word did not return to ready");

  // a result appears only after a final mix step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without final mix");

  // the hash register is loaded only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending hash overwritten");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the streaming multiply/xorshift 64-bit hash block.
`timescale 1ns / 100ps

module tb_top
  import mxh_pkg::*;
;

  localparam int LAT_CYCLES = 16;        // settle time before a start-value write
  localparam int PHASE_ITEMS = 616;      // random items per idling phase

  // One input item as it crosses the handshake
  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
    logic        continue_from_last;
  } word_t;

  // What the driver does next
  typedef enum logic [1:0] {
    ST_WORD,   // send one input item
    ST_SEED,   // write start_hash once the block is idle
    ST_DRAIN,  // hold off until every hash has come back
    ST_PACE    // change the idle rates of both sides
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    word_t       w;
    logic [63:0] seed;
    int          send_pct;
    int          recv_pct;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] data_word = '0;
  logic [3:0]  byte_count = '0;
  logic        last_word = 1'b0;
  logic        continue_from_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] hash;

  step_t       plan_q[$];
  logic [63:0] digest_q[$];
  int          send_pct = 0;
  int          recv_pct = 0;
  int          quiet = 0;
  int          errors = 0;

  // Predictor state
  logic [63:0] seed_reg = '0;
  logic [63:0] mix_acc = '0;
  logic [63:0] len_acc = '0;
  logic        mid_msg = 1'b0;
  logic [63:0] prior_hash = '0;

  multiply_xorshift_hash64 u_top (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_ready, .data_word, .byte_count, .last_word, .continue_from_last,
    .out_valid, .out_ready, .hash
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one accepted item into the running hash; done is set on a last word
  task automatic absorb_word(input word_t w, output bit done, output logic [63:0] digest);
    logic [63:0] x;
    logic [63:0] masked;
    logic [3:0]  n;
    n = (w.byte_count > WORD_BYTES) ? 4'(WORD_BYTES) : w.byte_count;
    if (!mid_msg) begin
      mix_acc = (w.continue_from_last ? prior_hash : seed_reg) ^ START_XOR;
      len_acc = '0;
      mid_msg = 1'b1;
    end
    if (n != 0) begin
      masked = w.data_word;
      if (n < WORD_BYTES) masked &= (64'd1 << (8 * n)) - 64'd1;
      x = mix_acc ^ masked;
      x = x * WORD_MUL;
      x ^= x >> WORD_SHIFT;
      mix_acc = x;
      len_acc += 64'(n);
    end
    done = w.last_word;
    digest = '0;
    if (done) begin
      x = mix_acc ^ len_acc;
      x = x * FINAL_MUL;
      x ^= x >> FINAL_SHIFT;
      prior_hash = x;
      mid_msg = 1'b0;
      digest = x;
    end
  endtask

  task automatic push_word(input logic [63:0] d, input logic [3:0] cnt, input logic lst,
                           input logic chn);
    step_t s;
    s.kind = ST_WORD;
    s.w = '{data_word: d, byte_count: cnt, last_word: lst, continue_from_last: chn};
    s.seed = '0;
    s.send_pct = 0;
    s.recv_pct = 0;
    plan_q.push_back(s);
  endtask

  task automatic push_ctl(input step_kind_t k, input logic [63:0] seed, input int sp,
                          input int rp);
    step_t s;
    s.kind = k;
    s.w = '0;
    s.seed = seed;
    s.send_pct = sp;
    s.recv_pct = rp;
    plan_q.push_back(s);
  endtask

  // Driver: items, start-value writes, hold-offs and pacing changes
  always @(posedge clk) begin
    logic nv;
    logic ncv;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nv  = in_valid;
      ncv = cfg_valid;
      if (in_valid && in_ready) nv = 1'b0;
      if (cfg_valid && cfg_ready) ncv = 1'b0;
      if (!nv && !ncv && plan_q.size() != 0) begin
        case (plan_q[0].kind)
          ST_WORD: begin
            if ($urandom_range(99) >= send_pct) begin
              data_word          <= plan_q[0].w.data_word;
              byte_count         <= plan_q[0].w.byte_count;
              last_word          <= plan_q[0].w.last_word;
              continue_from_last <= plan_q[0].w.continue_from_last;
              nv = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          ST_SEED: begin
            if (!in_valid && !cfg_valid && quiet >= LAT_CYCLES) begin
              cfg_data <= plan_q[0].seed;
              ncv = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          ST_DRAIN: begin
            if (!in_valid && !cfg_valid && quiet >= LAT_CYCLES) void'(plan_q.pop_front());
          end
          ST_PACE: begin
            send_pct <= plan_q[0].send_pct;
            recv_pct <= plan_q[0].recv_pct;
            void'(plan_q.pop_front());
          end
          default: void'(plan_q.pop_front());
        endcase
      end
      in_valid  <= nv;
      cfg_valid <= ncv;
    end
  end

  // Monitor: predict on accepted items, check accepted hashes, stall the output
  always @(posedge clk) begin
    bit          fin;
    bit          busy;
    logic [63:0] dg;
    logic [63:0] exp_h;
    if (rst) begin
      out_ready <= 1'b0;
      quiet     <= 0;
    end else begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) seed_reg = cfg_data;
      if (in_valid && in_ready) begin
        absorb_word('{data_word, byte_count, last_word, continue_from_last}, fin, dg);
        if (fin) digest_q.push_back(dg);
        busy = 1'b1;
      end
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (digest_q.size() == 0) begin
          $error("hash: no item expected, actual %h", hash);
          errors++;
        end else begin
          exp_h = digest_q.pop_front();
          if (hash !== exp_h) begin
            $error("hash: expected %h, actual %h", exp_h, hash);
            errors++;
          end
        end
      end
      quiet     <= (busy || cfg_valid || digest_q.size() != 0) ? 0 : quiet + 1;
      out_ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Plan the run, release reset, wait for the last hash
  initial begin
    int pace_send[3];
    int pace_recv[3];
    int sent;
    int nwords;
    int tail;
    bit broken;
    bit chain;
    bit drained;
    pace_send = '{6, 63, 0};
    pace_recv = '{63, 6, 0};
    drained = 1'b0;

    // Directed: field extremes and corner cases
    push_ctl(ST_PACE, '0, pace_send[0], pace_recv[0]);
    push_ctl(ST_SEED, 64'h0, 0, 0);
    push_word(64'h0, 4'd0, 1'b1, 1'b0);                    // empty message
    push_word('1, 4'd8, 1'b1, 1'b0);                       // one full word
    push_word('1, 4'd8, 1'b1, 1'b1);                       // chained start
    push_word(64'h5555_5555_5555_5555, 4'd3, 1'b0, 1'b0);  // short word, not last
    push_word('1, 4'd0, 1'b0, 1'b0);                       // zero count mid-message
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 4'd15, 1'b0, 1'b1); // saturating count, chain ignored
    push_word('1, 4'd9, 1'b1, 1'b0);
    for (int c = 1; c < 8; c++) push_word({$urandom, $urandom}, 4'(c), 1'b1, 1'(c));
    push_word(64'h0, 4'd8, 1'b1, 1'b1);
    push_ctl(ST_SEED, '1, 0, 0);
    push_word('1, 4'd0, 1'b1, 1'b0);
    push_word(64'h0, 4'd8, 1'b0, 1'b0);
    push_word('1, 4'd8, 1'b0, 1'b0);
    push_word(64'h8000_0000_0000_0001, 4'd12, 1'b1, 1'b1);

    // Random messages: mostly full words and a tail, some malformed counts
    for (int ph = 0; ph < 3; ph++) begin
      push_ctl(ST_PACE, '0, pace_send[ph], pace_recv[ph]);
      push_ctl(ST_SEED, {$urandom, $urandom}, 0, 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        nwords = $urandom_range(5);
        broken = ($urandom_range(99) < 15);
        chain  = 1'($urandom_range(1));
        for (int k = 0; k < nwords; k++)
          push_word({$urandom, $urandom}, broken ? 4'($urandom_range(15)) : 4'd8, 1'b0,
                    (k == 0) ? chain : 1'($urandom_range(1)));
        if (broken) tail = $urandom_range(15);
        else if (nwords == 0) tail = $urandom_range(8);
        else tail = $urandom_range(8, 1);
        push_word({$urandom, $urandom}, 4'(tail), 1'b1,
                  (nwords == 0) ? chain : 1'($urandom_range(1)));
        sent += nwords + 1;
        if (ph == 0 && !drained && sent > PHASE_ITEMS / 2) begin
          push_ctl(ST_DRAIN, '0, 0, 0);
          drained = 1'b1;
        end
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (!(plan_q.size() == 0 && !in_valid && !cfg_valid && quiet >= LAT_CYCLES));

    if (digest_q.size() != 0) begin
      $error("hash: %0d expected items never arrived", digest_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
